### hdl/kslpd_pkg.sv
// shared constants and register codes for the key short/long press detector
package kslpd_pkg;

    localparam int KEY_MASK_W   = 4;
    localparam int KEY_IDX_W    = 2;
    localparam int CNT_W        = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int NUM_KEYS_DEF = 4;

    localparam logic [CNT_W-1:0] COUNT_TOP = 16'hFFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_POLARITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_THRESH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_THRESH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_ENABLE  = 3'd4;

    // reset values of the registers
    localparam logic [KEY_MASK_W-1:0] RST_KEY_ENABLE   = 4'd1;
    localparam logic [KEY_MASK_W-1:0] RST_KEY_POLARITY = 4'd0;
    localparam logic [CNT_W-1:0]      RST_SHORT_THRESH = 16'd3;
    localparam logic [CNT_W-1:0]      RST_LONG_THRESH  = 16'd100;
    localparam logic                  RST_LONG_ENABLE  = 1'b1;

    // event kinds
    localparam logic EV_SHORT = 1'b0;
    localparam logic EV_LONG  = 1'b1;

endpackage

### hdl/key_short_long_press_detector.sv
// key short/long press detector: per-key hold counters and an event queue
//
//  channel  | direction | handshake           | payload
//  s_       | in        | s_valid / s_ready   | s_key_levels
//  m_       | out       | m_valid / m_ready   | m_key_index, m_event_kind,
//           |           |                     | m_press_count, m_last_event
//  cfg_     | in        | cfg_wr_en           | cfg_index, cfg_wr_data
//
// a scan tick updates the counters of all enabled keys in the cycle it is
// taken and queues its events in per-key event registers; one event leaves
// per cycle while m_ready is high, in ascending key order.
// the next tick is taken in the cycle the last queued event transfers.
// reset (aresetn low, synchronous) clears counters, long marks, the queue
// and loads the register defaults.
module key_short_long_press_detector #(
    parameter int NUM_KEYS = kslpd_pkg::NUM_KEYS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [kslpd_pkg::KEY_MASK_W-1:0]  s_key_levels,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [kslpd_pkg::KEY_IDX_W-1:0]   m_key_index,
    output logic                              m_event_kind,
    output logic [kslpd_pkg::CNT_W-1:0]       m_press_count,
    output logic                              m_last_event,
    input  logic                              cfg_wr_en,
    input  logic [kslpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kslpd_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import kslpd_pkg::*;

    // keys beyond the mask width can never be enabled
    localparam int ACT_KEYS = (NUM_KEYS < KEY_MASK_W) ? NUM_KEYS : KEY_MASK_W;

    logic [KEY_MASK_W-1:0] key_enable_reg;
    logic [KEY_MASK_W-1:0] key_polarity_reg;
    logic [CNT_W-1:0]      short_threshold_reg;
    logic [CNT_W-1:0]      long_threshold_reg;
    logic                  long_enable_reg;

    logic [CNT_W-1:0]      hold_count_reg  [ACT_KEYS];
    logic [CNT_W-1:0]      hold_count_next [ACT_KEYS];
    logic [ACT_KEYS-1:0]   long_rep_reg;
    logic [ACT_KEYS-1:0]   long_rep_next;

    logic [ACT_KEYS-1:0]   pend_reg;
    logic [ACT_KEYS-1:0]   pend_next;
    logic [ACT_KEYS-1:0]   ev_kind_reg;
    logic [ACT_KEYS-1:0]   ev_kind_next;
    logic [CNT_W-1:0]      ev_count_reg  [ACT_KEYS];
    logic [CNT_W-1:0]      ev_count_next [ACT_KEYS];

    logic [CNT_W-1:0]      count_inc [ACT_KEYS];
    logic [CNT_W-1:0]      count_eff [ACT_KEYS];
    logic [ACT_KEYS-1:0]   held;
    logic [ACT_KEYS-1:0]   new_events;
    logic [ACT_KEYS-1:0]   pend_low;
    logic [ACT_KEYS-1:0]   pend_rest;
    logic                  s_xfer;
    logic                  m_xfer;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_enable_reg      <= RST_KEY_ENABLE;
            key_polarity_reg    <= RST_KEY_POLARITY;
            short_threshold_reg <= RST_SHORT_THRESH;
            long_threshold_reg  <= RST_LONG_THRESH;
            long_enable_reg     <= RST_LONG_ENABLE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_KEY_ENABLE:   key_enable_reg      <= cfg_wr_data[KEY_MASK_W-1:0];
                REG_KEY_POLARITY: key_polarity_reg    <= cfg_wr_data[KEY_MASK_W-1:0];
                REG_SHORT_THRESH: short_threshold_reg <= cfg_wr_data[CNT_W-1:0];
                REG_LONG_THRESH:  long_threshold_reg  <= cfg_wr_data[CNT_W-1:0];
                REG_LONG_ENABLE:  long_enable_reg     <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // per-key counter update and event generation for one tick
    always_comb begin
        hold_count_next = hold_count_reg;
        long_rep_next   = long_rep_reg;
        new_events      = '0;
        ev_kind_next    = ev_kind_reg;
        ev_count_next   = ev_count_reg;
        for (int k = 0; k < ACT_KEYS; k++) begin
            held[k]      = ~(s_key_levels[k] ^ key_polarity_reg[k]);
            count_inc[k] = hold_count_reg[k] + CNT_W'(1);
            // a reported long press leaves the count at zero for the release check
            count_eff[k] = long_rep_reg[k] ? '0 : hold_count_reg[k];
            if (key_enable_reg[k]) begin
                if (held[k]) begin
                    if (!long_rep_reg[k]) begin
                        if (long_enable_reg && (count_inc[k] >= long_threshold_reg)) begin
                            long_rep_next[k]   = 1'b1;
                            new_events[k]      = 1'b1;
                            ev_kind_next[k]    = EV_LONG;
                            ev_count_next[k]   = count_inc[k];
                            hold_count_next[k] = '0;
                        end else if (count_inc[k] == COUNT_TOP) begin
                            hold_count_next[k] = '0;
                        end else begin
                            hold_count_next[k] = count_inc[k];
                        end
                    end else begin
                        hold_count_next[k] = '0;
                    end
                end else begin
                    if (count_eff[k] >= short_threshold_reg) begin
                        new_events[k]    = 1'b1;
                        ev_kind_next[k]  = EV_SHORT;
                        ev_count_next[k] = count_eff[k];
                    end
                    long_rep_next[k]   = 1'b0;
                    hold_count_next[k] = '0;
                end
            end
        end
    end

    // lowest pending key leaves first
    assign pend_low  = pend_reg & (~pend_reg + ACT_KEYS'(1));
    assign pend_rest = pend_reg & ~pend_low;

    assign m_valid      = |pend_reg;
    assign m_last_event = (pend_rest == '0);
    assign m_xfer       = m_valid && m_ready;
    assign s_ready      = (pend_reg == '0) || (m_ready && (pend_rest == '0));
    assign s_xfer       = s_valid && s_ready;

    always_comb begin
        m_key_index   = '0;
        m_event_kind  = EV_SHORT;
        m_press_count = '0;
        for (int k = ACT_KEYS - 1; k >= 0; k--) begin
            if (pend_reg[k]) begin
                m_key_index   = KEY_IDX_W'(k);
                m_event_kind  = ev_kind_reg[k];
                m_press_count = ev_count_reg[k];
            end
        end
    end

    always_comb begin
        pend_next = pend_reg;
        if (s_xfer) begin
            pend_next = new_events;
        end else if (m_xfer) begin
            pend_next = pend_rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < ACT_KEYS; k++) begin
                hold_count_reg[k] <= '0;
            end
            long_rep_reg <= '0;
            pend_reg     <= '0;
        end else begin
            pend_reg <= pend_next;
            if (s_xfer) begin
                hold_count_reg <= hold_count_next;
                long_rep_reg   <= long_rep_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            ev_kind_reg  <= ev_kind_next;
            ev_count_reg <= ev_count_next;
        end
    end

    // a stalled input side always has an event waiting
    a_stall_has_event: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no pending event");

    // the queue only gains events when a tick is taken
    a_queue_no_growth: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_xfer |=> ((pend_reg & ~$past(pend_reg)) == '0))
        else $error("event queue grew without a tick transfer");

    genvar g;
    for (g = 0; g < ACT_KEYS; g++) begin : g_key_chk
        // after a long report the counter sits at zero until release
        a_long_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
            long_rep_reg[g] |-> (hold_count_reg[g] == '0))
            else $error("hold count nonzero after long report");

        // the counter never rests at its top value
        a_count_below_top: assert property (@(posedge aclk) disable iff (!aresetn)
            hold_count_reg[g] != COUNT_TOP)
            else $error("hold count reached its top value");
    end

endmodule
